// ===== design/steer_command_arbiter_core_defines.svh =====
// Assertion macros shared by the steering arbiter checker.
`ifndef STEER_COMMAND_ARBITER_CORE_DEFINES_SVH
`define STEER_COMMAND_ARBITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sca_pkg.sv =====
// Types and constants of the steering command arbiter.
`default_nettype none
package sca_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ESTOP = 3'd1,
    CMD_OPER  = 3'd2,
    CMD_PC    = 3'd3,
    CMD_CAN   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_ESTOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_OPER = 2'd1,
    SRC_PC   = 2'd2,
    SRC_CAN  = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_APPLY
  } state_e;

  localparam logic [2:0] REG_LINK_MODE = 3'd0;
  localparam logic [2:0] REG_TO_REL    = 3'd1;
  localparam logic [2:0] REG_ETH_TO    = 3'd2;
  localparam logic [2:0] REG_CAN_TO    = 3'd3;
  localparam logic [2:0] REG_ADC_MIN   = 3'd4;
  localparam logic [2:0] REG_ADC_MAX   = 3'd5;
  localparam logic [2:0] REG_ADC_CTR   = 3'd6;
  localparam logic [2:0] REG_ADC_DB    = 3'd7;

  localparam logic [1:0] LINK_ETH_ONLY = 2'd0;
  localparam logic [1:0] LINK_CAN_ONLY = 2'd1;

  localparam logic [7:0] OPM_AUTO   = 8'd1;
  localparam logic [7:0] OPM_MANUAL = 8'd2;
  localparam logic [7:0] OPM_ESTOP  = 8'd3;

  localparam logic [2:0] ESRC_OPER = 3'b001;
  localparam logic [2:0] ESRC_PC   = 3'b010;
  localparam logic [2:0] ESRC_CAN  = 3'b100;

  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 18;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== design/sca_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module sca_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sca_pkg::div_req_t             req_i,
  output logic                               busy_o,
  output logic [sca_pkg::DIV_NUM_W-1:0]      quot_o
);
  localparam int CntW = $clog2(sca_pkg::DIV_NUM_W + 1);

  logic                          busy_q;
  logic [CntW-1:0]               cnt_q;
  logic [sca_pkg::DIV_DEN_W-1:0] rem_q;
  logic [sca_pkg::DIV_DEN_W-1:0] den_q;
  logic [sca_pkg::DIV_NUM_W-1:0] quo_q;
  logic [sca_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[sca_pkg::DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(sca_pkg::DIV_NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (busy_q) begin
      rem_q <= fits ? sca_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                    : trial[sca_pkg::DIV_DEN_W-1:0];
      quo_q <= {quo_q[sca_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ===== design/steer_command_arbiter_core.sv =====
// Top level of the steering command arbiter: sequencer, state and ports.
//
// The block takes one item at a time on the s_axis channel. The kind of item
// (tick, estop event, operator packet, PC packet, CAN request) travels in
// tuser, the packet fields in tdata. For every accepted item exactly one
// result leaves on m_axis, showing mode, source, target and flags after the
// item has been applied.
// Operator manual packets and CAN steering requests go through one shared
// multiplier and one serial divider that yields a quotient bit per cycle,
// so such an item is applied only once the divider has produced all 49
// quotient bits. Every other item goes from the multiplier straight to the
// apply state. Either way the next item is taken only after the sequencer
// has applied the current one and returned to idle.
// s_axis_tready is high only while the sequencer is idle. A result sits in
// the state registers themselves; when the receiver stalls it stays valid and
// unchanged, the next item is still taken and worked on, and it is applied
// only once the waiting result has been taken.
// Configuration writes on the cfg channel are always taken and should only
// come while no item is in flight. Reset clears the state and loads the
// register defaults.
`default_nettype none
module steer_command_arbiter_core #(
  parameter int OPERATOR_SCALE_Q16 = 1966080,
  parameter int OPERATOR_POLARITY  = 1,
  parameter int PC_SCALE_Q16       = 655,
  parameter int PC_POLARITY        = 1,
  parameter int CAN_DIVISOR        = 100,
  parameter int PC_AUTO_ENTRY      = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // operator_mode[7:0], steer_value[39:8], stop_flag[40], estop_sources[43:41],
  // time_ms[75:44], encoder_ready[76], zero fill[79:77]
  input  wire logic [79:0] s_axis_tdata,
  // command[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mode[1:0], steer_source[3:2], steer_target[35:4], control_on[36],
  // servo_on[37], eth_timed_out[38], can_timed_out[39],
  // last_estop_sources[42:40], zero fill[47:43]
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [1:0]         link_q, rel_q;
  logic [15:0]        eth_to_q, can_to_q;
  logic signed [15:0] amin_q, amax_q, actr_q;
  logic [14:0]        adb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= 2'd0;
      rel_q    <= 2'd0;
      eth_to_q <= 16'd200;
      can_to_q <= 16'd200;
      amin_q   <= 16'sd0;
      amax_q   <= 16'sd4095;
      actr_q   <= 16'sd2048;
      adb_q    <= 15'd20;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sca_pkg::REG_LINK_MODE: link_q   <= cfg_data_i[1:0];
        sca_pkg::REG_TO_REL:    rel_q    <= cfg_data_i[1:0];
        sca_pkg::REG_ETH_TO:    eth_to_q <= cfg_data_i;
        sca_pkg::REG_CAN_TO:    can_to_q <= cfg_data_i;
        sca_pkg::REG_ADC_MIN:   amin_q   <= cfg_data_i;
        sca_pkg::REG_ADC_MAX:   amax_q   <= cfg_data_i;
        sca_pkg::REG_ADC_CTR:   actr_q   <= cfg_data_i;
        sca_pkg::REG_ADC_DB:    adb_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [2:0]         cmd_q;
  logic [7:0]         opm_q;
  logic signed [31:0] sv_q;
  logic               stop_q, rdy_q;
  logic [2:0]         esrc_q;
  logic [31:0]        now_q;

  // Arbiter state, which doubles as the result register.
  logic [1:0]         mode_q, mode_d, src_q, src_d;
  logic signed [31:0] tgt_q, tgt_d;
  logic               ctl_q, ctl_d, srv_q, srv_d;
  logic [31:0]        eth_last_q, eth_last_d, can_last_q, can_last_d;
  logic               eth_to_flag_q, eth_to_flag_d, can_to_flag_q, can_to_flag_d;
  logic [2:0]         erec_q, erec_d;
  logic               ovalid_q;

  sca_pkg::state_e state_q, state_d;

  logic s_acc, out_free, apply_go, div_busy, need_div_q;
  logic eth_on, can_on;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign apply_go = (state_q == sca_pkg::ST_APPLY) && out_free;
  assign eth_on   = link_q != sca_pkg::LINK_CAN_ONLY;
  assign can_on   = link_q != sca_pkg::LINK_ETH_ONLY;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sca_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = sca_pkg::ST_CALC;
      sca_pkg::ST_CALC:   state_d = sca_pkg::ST_MUL;
      sca_pkg::ST_MUL:    state_d = need_div_q ? sca_pkg::ST_DSTART : sca_pkg::ST_APPLY;
      sca_pkg::ST_DSTART: state_d = sca_pkg::ST_DIV;
      sca_pkg::ST_DIV:    if (!div_busy) state_d = sca_pkg::ST_APPLY;
      sca_pkg::ST_APPLY:  if (out_free) state_d = sca_pkg::ST_IDLE;
      default:            state_d = sca_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = state_q == sca_pkg::ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sca_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q  <= s_axis_tuser;
      opm_q  <= s_axis_tdata[7:0];
      sv_q   <= s_axis_tdata[39:8];
      stop_q <= s_axis_tdata[40];
      esrc_q <= s_axis_tdata[43:41];
      now_q  <= s_axis_tdata[75:44];
      rdy_q  <= s_axis_tdata[76];
    end
  end

  // Operand preparation: operator clamp, deadband and span, CAN magnitude.
  logic signed [16:0] raw16, mn, mx, ce, vc1, vc;
  logic signed [17:0] off, offz, dbs, pos, neg;
  logic               bad;
  logic signed [32:0] mul_a_d, mul_a_q, mul_b_d, mul_b_q;
  logic [16:0]        half_d, half_q;
  logic               neg_d, neg_q, zero_d, zero_q, need_div_d;

  always_comb begin
    raw16 = {sv_q[15], sv_q[15:0]};
    mn    = {amin_q[15], amin_q};
    mx    = {amax_q[15], amax_q};
    ce    = {actr_q[15], actr_q};
    vc1   = (raw16 > mx) ? mx : raw16;
    vc    = (vc1 < mn) ? mn : vc1;
    off   = 18'(vc) - 18'(ce);
    dbs   = {3'b000, adb_q};
    offz  = (off <= dbs && off >= -dbs) ? 18'sd0 : off;
    pos   = 18'(mx) - 18'(ce);
    neg   = 18'(ce) - 18'(mn);
    bad   = (pos <= 18'sd0) || (neg <= 18'sd0) || (OPERATOR_POLARITY == 0);

    mul_a_d = 33'(sv_q);
    mul_b_d = 33'(PC_SCALE_Q16);
    half_d  = 17'd0;
    neg_d   = 1'b0;
    zero_d  = 1'b0;
    unique case (cmd_q)
      sca_pkg::CMD_OPER: begin
        mul_a_d = (offz < 18'sd0) ? 33'(-offz) : 33'(offz);
        mul_b_d = 33'(OPERATOR_SCALE_Q16);
        half_d  = (offz < 18'sd0) ? neg[16:0] : pos[16:0];
        neg_d   = offz < 18'sd0;
        zero_d  = bad;
      end
      sca_pkg::CMD_CAN: begin
        mul_a_d = (raw16 < 17'sd0) ? 33'(-raw16) : 33'(raw16);
        mul_b_d = 33'sd65536;
        half_d  = 17'(CAN_DIVISOR);
        neg_d   = raw16 < 17'sd0;
        zero_d  = CAN_DIVISOR <= 0;
      end
      default: ;
    endcase

    need_div_d = ((cmd_q == sca_pkg::CMD_OPER) && eth_on && (opm_q == sca_pkg::OPM_MANUAL)) ||
                 ((cmd_q == sca_pkg::CMD_CAN) && !stop_q && (link_q == sca_pkg::LINK_CAN_ONLY));
  end

  // Shared multiplier, registered.
  logic signed [65:0] prod;
  logic signed [63:0] prod_q;
  assign prod = mul_a_q * mul_b_q;

  always_ff @(posedge clk_i) begin
    if (state_q == sca_pkg::ST_CALC) begin
      mul_a_q    <= mul_a_d;
      mul_b_q    <= mul_b_d;
      half_q     <= half_d;
      neg_q      <= neg_d;
      zero_q     <= zero_d;
      need_div_q <= need_div_d;
    end
    if (state_q == sca_pkg::ST_MUL) begin
      prod_q <= prod[63:0];
    end
  end

  sca_pkg::div_req_t             div_req;
  logic [sca_pkg::DIV_NUM_W-1:0] quot;

  assign div_req.start = state_q == sca_pkg::ST_DSTART;
  assign div_req.num   = {prod_q[47:0], 1'b0} + sca_pkg::DIV_NUM_W'(half_q);
  assign div_req.den   = {half_q, 1'b0};

  sca_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  // Degrees from the quotient or the product.
  logic [31:0]        opmag, canmag;
  logic signed [31:0] op_deg, can_deg, pc_deg;
  logic signed [63:0] pcr;

  always_comb begin
    opmag  = (quot > sca_pkg::DIV_NUM_W'(OPERATOR_SCALE_Q16)) ? 32'(OPERATOR_SCALE_Q16)
                                                               : quot[31:0];
    op_deg = zero_q ? 32'sd0
           : ((neg_q ^ (OPERATOR_POLARITY < 0)) ? -$signed(opmag) : $signed(opmag));
    canmag = (quot > sca_pkg::DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[31:0];
    can_deg = zero_q ? 32'sd0 : (neg_q ? -$signed(canmag) : $signed(canmag));
    pcr = (PC_POLARITY == 0) ? 64'sd0 : ((PC_POLARITY < 0) ? -prod_q : prod_q);
    if (pcr > 64'sd2147483647) begin
      pc_deg = 32'sh7FFF_FFFF;
    end else if (pcr < -64'sd2147483648) begin
      pc_deg = 32'sh8000_0000;
    end else begin
      pc_deg = pcr[31:0];
    end
  end

  // Arbitration of the item against the current state.
  logic [2:0]  srcs;
  logic [31:0] eth_el, can_el;

  always_comb begin
    mode_d        = mode_q;
    src_d         = src_q;
    tgt_d         = tgt_q;
    ctl_d         = ctl_q;
    srv_d         = srv_q;
    eth_last_d    = eth_last_q;
    can_last_d    = can_last_q;
    eth_to_flag_d = eth_to_flag_q;
    can_to_flag_d = can_to_flag_q;
    erec_d        = erec_q;
    srcs          = esrc_q;
    eth_el        = now_q - eth_last_q;
    can_el        = now_q - can_last_q;

    unique case (cmd_q)
      sca_pkg::CMD_TICK: begin
        if (eth_on && eth_last_q != 32'd0 && !eth_to_flag_q && eth_el > 32'(eth_to_q)) begin
          eth_to_flag_d = 1'b1;
          if (rel_q[0]) begin
            ctl_d = 1'b0;
            srv_d = 1'b0;
            src_d = sca_pkg::SRC_NONE;
          end
        end
        if (can_on && can_last_q != 32'd0) begin
          if (can_el <= 32'(can_to_q)) begin
            can_to_flag_d = 1'b0;
          end else begin
            can_to_flag_d = 1'b1;
            if (link_q == sca_pkg::LINK_CAN_ONLY && rel_q[1]) begin
              ctl_d = 1'b0;
              srv_d = 1'b0;
              src_d = sca_pkg::SRC_NONE;
            end
          end
        end
      end
      sca_pkg::CMD_ESTOP: begin
        if (!eth_on) srcs = srcs & sca_pkg::ESRC_CAN;
        if (!can_on) srcs = srcs & (sca_pkg::ESRC_OPER | sca_pkg::ESRC_PC);
        if (srcs != 3'd0) begin
          ctl_d  = 1'b0;
          srv_d  = 1'b0;
          src_d  = sca_pkg::SRC_NONE;
          mode_d = sca_pkg::MODE_ESTOP;
          erec_d = srcs;
        end
      end
      sca_pkg::CMD_OPER: begin
        if (eth_on) begin
          if (opm_q == sca_pkg::OPM_AUTO) begin
            mode_d = sca_pkg::MODE_AUTO;
          end else if (opm_q == sca_pkg::OPM_MANUAL) begin
            mode_d = sca_pkg::MODE_MANUAL;
            ctl_d  = rdy_q;
            srv_d  = rdy_q;
            src_d  = rdy_q ? sca_pkg::SRC_OPER : sca_pkg::SRC_NONE;
            if (rdy_q) tgt_d = op_deg;
            eth_last_d    = now_q;
            eth_to_flag_d = 1'b0;
          end else if (opm_q == sca_pkg::OPM_ESTOP) begin
            ctl_d  = 1'b0;
            srv_d  = 1'b0;
            src_d  = sca_pkg::SRC_NONE;
            mode_d = sca_pkg::MODE_ESTOP;
            erec_d = sca_pkg::ESRC_OPER;
          end
        end
      end
      sca_pkg::CMD_PC: begin
        if (eth_on) begin
          if (stop_q) begin
            ctl_d  = 1'b0;
            srv_d  = 1'b0;
            src_d  = sca_pkg::SRC_NONE;
            mode_d = sca_pkg::MODE_ESTOP;
            erec_d = sca_pkg::ESRC_PC;
          end else begin
            if (PC_AUTO_ENTRY != 0 && mode_q == sca_pkg::MODE_NONE) begin
              mode_d = sca_pkg::MODE_AUTO;
            end
            if (mode_d == sca_pkg::MODE_AUTO) begin
              ctl_d  = rdy_q;
              srv_d  = rdy_q;
              src_d  = rdy_q ? sca_pkg::SRC_PC : sca_pkg::SRC_NONE;
              if (rdy_q) tgt_d = pc_deg;
              eth_last_d    = now_q;
              eth_to_flag_d = 1'b0;
            end
          end
        end
      end
      sca_pkg::CMD_CAN: begin
        if (can_on) begin
          if (stop_q) begin
            ctl_d  = 1'b0;
            srv_d  = 1'b0;
            src_d  = sca_pkg::SRC_NONE;
            mode_d = sca_pkg::MODE_ESTOP;
            erec_d = sca_pkg::ESRC_CAN;
          end else begin
            can_last_d    = now_q;
            can_to_flag_d = 1'b0;
            if (link_q == sca_pkg::LINK_CAN_ONLY) begin
              mode_d = sca_pkg::MODE_AUTO;
              ctl_d  = rdy_q;
              srv_d  = rdy_q;
              src_d  = rdy_q ? sca_pkg::SRC_CAN : sca_pkg::SRC_NONE;
              if (rdy_q) tgt_d = can_deg;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= sca_pkg::MODE_NONE;
      src_q         <= sca_pkg::SRC_NONE;
      tgt_q         <= 32'sd0;
      ctl_q         <= 1'b0;
      srv_q         <= 1'b0;
      eth_last_q    <= 32'd0;
      can_last_q    <= 32'd0;
      eth_to_flag_q <= 1'b0;
      can_to_flag_q <= 1'b0;
      erec_q        <= 3'd0;
      ovalid_q      <= 1'b0;
    end else begin
      if (apply_go) begin
        mode_q        <= mode_d;
        src_q         <= src_d;
        tgt_q         <= tgt_d;
        ctl_q         <= ctl_d;
        srv_q         <= srv_d;
        eth_last_q    <= eth_last_d;
        can_last_q    <= can_last_d;
        eth_to_flag_q <= eth_to_flag_d;
        can_to_flag_q <= can_to_flag_d;
        erec_q        <= erec_d;
        ovalid_q      <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, erec_q, can_to_flag_q, eth_to_flag_q, srv_q, ctl_q,
                          tgt_q, src_q, mode_q};

endmodule
`default_nettype wire

// ===== design/sca_checker.sv =====
// Port-level checker for the steering command arbiter, bound to the top level.
`default_nettype none
`include "steer_command_arbiter_core_defines.svh"
module sca_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  logic s_acc, held, estop_out, drive_out;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign held      = m_axis_tvalid && !m_axis_tready;
  assign estop_out = m_axis_tvalid && (m_axis_tdata[1:0] == sca_pkg::MODE_ESTOP);
  assign drive_out = m_axis_tvalid && (m_axis_tdata[3:2] != sca_pkg::SRC_NONE);

  `SCA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_acc, !s_axis_tready, "ready after accept")
  `SCA_ASSERT_NXT(a_result_held, clk_i, rst_ni, held,
                  m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `SCA_ASSERT_IMP(a_estop_drive_off, clk_i, rst_ni, estop_out,
                  !m_axis_tdata[36] && !m_axis_tdata[37], "drive enabled in estop")
  `SCA_ASSERT_IMP(a_source_enables, clk_i, rst_ni, drive_out,
                  m_axis_tdata[36] && m_axis_tdata[37], "source without enables")
endmodule

bind steer_command_arbiter_core sca_checker u_sca_checker (.*);
`default_nettype wire

// ===== tb/sv/steer_command_arbiter_core_test.sv =====
// Self-checking testbench of the steering command arbiter core.
`timescale 1ns / 1ps
module steer_command_arbiter_core_test;

  // Command codes that the block does not use; such items leave the state unchanged.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam longint OPER_SCALE  = 1966080;
  localparam longint PC_SCALE    = 655;
  localparam longint CAN_DIV     = 100;
  localparam int     PHASE_ITEMS = 110;
  localparam int     WATCH_LIMIT = 6000;
  localparam int     RX_HOLD     = 400;

  // One input item of the arbiter, field by field.
  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  opm;
    logic [31:0] steer;
    logic        stop;
    logic [2:0]  srcs;
    logic [31:0] tms;
    logic        rdy;
  } steer_item_t;

  // The status that the arbiter reports after each item.
  typedef struct {
    sca_pkg::mode_e mode;
    sca_pkg::src_e  src;
    logic [31:0]    tgt;
    logic           ctl;
    logic           srv;
    logic           eto;
    logic           cto;
    logic [2:0]     est;
  } steer_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  steer_command_arbiter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Items waiting to be offered, and the status words expected back, oldest first.
  steer_item_t   pending_items[$];
  steer_status_t expected_status[$];

  int          error_count = 0;
  int          items_taken = 0;
  int          status_taken = 0;
  bit          calm = 1'b0;
  logic [31:0] now_ms = 32'd1;

  // Shadow registers of the configuration, at their reset values.
  logic [1:0]  sh_link = 2'd0;
  logic [1:0]  sh_release = 2'd0;
  logic [15:0] sh_eth_to = 16'd200;
  logic [15:0] sh_can_to = 16'd200;
  logic [15:0] sh_adc_min = 16'd0;
  logic [15:0] sh_adc_max = 16'd4095;
  logic [15:0] sh_adc_ctr = 16'd2048;
  logic [14:0] sh_adc_db = 15'd20;

  // Shadow of the arbiter state.
  sca_pkg::mode_e sh_mode = sca_pkg::MODE_NONE;
  sca_pkg::src_e  sh_src = sca_pkg::SRC_NONE;
  logic [31:0]    sh_target = '0;
  logic           sh_ctl = 1'b0;
  logic           sh_srv = 1'b0;
  logic [31:0]    sh_eth_last = '0;
  logic [31:0]    sh_can_last = '0;
  logic           sh_eto = 1'b0;
  logic           sh_cto = 1'b0;
  logic [2:0]     sh_estop = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Operator raw value to degrees: clamp, deadband around the centre, then
  // normalise by the span on that side with rounding half away from zero.
  function automatic logic [31:0] operator_degrees(logic [15:0] raw16);
    longint v, mn, mx, ce, db, off, pos, neg, span, mag;
    v = $signed(raw16);
    mn = $signed(sh_adc_min);
    mx = $signed(sh_adc_max);
    ce = $signed(sh_adc_ctr);
    db = sh_adc_db;
    if (v > mx) v = mx;
    if (v < mn) v = mn;
    off = v - ce;
    if (off <= db && off >= -db) off = 0;
    pos = mx - ce;
    neg = ce - mn;
    if (pos <= 0 || neg <= 0) return '0;
    span = (off >= 0) ? pos : neg;
    mag = (off < 0) ? -off : off;
    mag = (mag * OPER_SCALE * 2 + span) / (2 * span);
    if (mag > OPER_SCALE) mag = OPER_SCALE;
    return (off < 0) ? 32'(-mag) : 32'(mag);
  endfunction

  // PC raw value scaled exactly and saturated to 32 bits signed.
  function automatic logic [31:0] pc_degrees(logic [31:0] raw);
    longint r;
    r = longint'($signed(raw)) * PC_SCALE;
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    return 32'(r);
  endfunction

  function automatic logic [31:0] can_degrees(logic [15:0] raw16);
    longint raw, mag;
    raw = $signed(raw16);
    mag = ((raw < 0) ? -raw : raw) * 65536;
    mag = (mag * 2 + CAN_DIV) / (2 * CAN_DIV);
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return (raw < 0) ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic void release_drive();
    sh_ctl = 1'b0;
    sh_srv = 1'b0;
    sh_src = sca_pkg::SRC_NONE;
  endfunction

  function automatic void enter_estop(logic [2:0] mask);
    release_drive();
    sh_mode = sca_pkg::MODE_ESTOP;
    sh_estop = mask;
  endfunction

  // Without position feedback the drive is released but the target is kept.
  function automatic void steer_to(logic [31:0] deg, sca_pkg::src_e src, logic rdy);
    if (!rdy) begin
      release_drive();
      return;
    end
    sh_target = deg;
    sh_ctl = 1'b1;
    sh_srv = 1'b1;
    sh_src = src;
  endfunction

  // Applies one item to the shadow state and returns the status it leads to.
  function automatic steer_status_t arbitrate(steer_item_t it);
    steer_status_t st;
    logic          eth_on;
    logic          can_on;
    logic [2:0]    srcs;
    eth_on = (sh_link != sca_pkg::LINK_CAN_ONLY);
    can_on = (sh_link != sca_pkg::LINK_ETH_ONLY);
    srcs = it.srcs;
    case (it.cmd)
      sca_pkg::CMD_TICK: begin
        // Ethernet timeout latches once; CAN timeout is re-evaluated every tick.
        if (eth_on && sh_eth_last != 0 && !sh_eto &&
            (it.tms - sh_eth_last) > {16'd0, sh_eth_to}) begin
          sh_eto = 1'b1;
          if (sh_release[0]) release_drive();
        end
        if (can_on && sh_can_last != 0) begin
          if ((it.tms - sh_can_last) <= {16'd0, sh_can_to}) begin
            sh_cto = 1'b0;
          end else begin
            sh_cto = 1'b1;
            if (sh_link == sca_pkg::LINK_CAN_ONLY && sh_release[1]) release_drive();
          end
        end
      end
      sca_pkg::CMD_ESTOP: begin
        if (!eth_on) srcs &= sca_pkg::ESRC_CAN;
        if (!can_on) srcs &= (sca_pkg::ESRC_OPER | sca_pkg::ESRC_PC);
        if (srcs != 0) enter_estop(srcs);
      end
      sca_pkg::CMD_OPER: begin
        if (eth_on) begin
          if (it.opm == sca_pkg::OPM_AUTO) begin
            sh_mode = sca_pkg::MODE_AUTO;
          end else if (it.opm == sca_pkg::OPM_MANUAL) begin
            sh_mode = sca_pkg::MODE_MANUAL;
            steer_to(operator_degrees(it.steer[15:0]), sca_pkg::SRC_OPER, it.rdy);
            sh_eth_last = it.tms;
            sh_eto = 1'b0;
          end else if (it.opm == sca_pkg::OPM_ESTOP) begin
            enter_estop(sca_pkg::ESRC_OPER);
          end
        end
      end
      sca_pkg::CMD_PC: begin
        if (eth_on) begin
          if (it.stop) begin
            enter_estop(sca_pkg::ESRC_PC);
          end else if (sh_mode == sca_pkg::MODE_AUTO) begin
            steer_to(pc_degrees(it.steer), sca_pkg::SRC_PC, it.rdy);
            sh_eth_last = it.tms;
            sh_eto = 1'b0;
          end
        end
      end
      sca_pkg::CMD_CAN: begin
        if (can_on) begin
          if (it.stop) begin
            enter_estop(sca_pkg::ESRC_CAN);
          end else begin
            sh_can_last = it.tms;
            sh_cto = 1'b0;
            // In the shared link modes a CAN request only refreshes its time stamp and timeout flag.
            if (sh_link == sca_pkg::LINK_CAN_ONLY) begin
              sh_mode = sca_pkg::MODE_AUTO;
              steer_to(can_degrees(it.steer[15:0]), sca_pkg::SRC_CAN, it.rdy);
            end
          end
        end
      end
      default: ;
    endcase
    st.mode = sh_mode;
    st.src = sh_src;
    st.tgt = sh_target;
    st.ctl = sh_ctl;
    st.srv = sh_srv;
    st.eto = sh_eto;
    st.cto = sh_cto;
    st.est = sh_estop;
    return st;
  endfunction

  function automatic steer_item_t make_item(logic [2:0] cmd, logic [7:0] opm,
                                            logic [31:0] steer, logic stop,
                                            logic [2:0] srcs, logic [31:0] tms,
                                            logic rdy);
    steer_item_t it;
    it.cmd = cmd;
    it.opm = opm;
    it.steer = steer;
    it.stop = stop;
    it.srcs = srcs;
    it.tms = tms;
    it.rdy = rdy;
    return it;
  endfunction

  // A random item. Time mostly creeps forward so that timeouts come and go,
  // with the odd zero stamp and the odd jump anywhere in the 32-bit range.
  function automatic steer_item_t random_item();
    steer_item_t it;
    int          r;
    int          pick;
    r = $urandom_range(0, 99);
    now_ms += $urandom_range(0, 140);
    if ($urandom_range(0, 39) == 0) now_ms = $urandom;
    it.tms = ($urandom_range(0, 29) == 0) ? 32'd0 : now_ms;
    it.opm = sca_pkg::OPM_MANUAL;
    it.stop = ($urandom_range(0, 9) == 0);
    it.srcs = 3'($urandom_range(0, 7));
    it.rdy = ($urandom_range(0, 9) != 0);
    it.steer = $urandom;
    // Most steering values stay near the configured operator range.
    if ($urandom_range(0, 3) != 0)
      it.steer[15:0] = sh_adc_ctr + 16'($signed($urandom_range(0, 8000)) - 4000);
    if (r < 28) begin
      it.cmd = sca_pkg::CMD_TICK;
    end else if (r < 33) begin
      it.cmd = sca_pkg::CMD_ESTOP;
    end else if (r < 60) begin
      it.cmd = sca_pkg::CMD_OPER;
      pick = $urandom_range(0, 19);
      if (pick < 4) it.opm = sca_pkg::OPM_AUTO;
      else if (pick < 5) it.opm = sca_pkg::OPM_ESTOP;
      else if (pick < 7) it.opm = 8'($urandom_range(0, 255));
    end else if (r < 78) begin
      it.cmd = sca_pkg::CMD_PC;
      if ($urandom_range(0, 2) != 0) it.steer = 32'($signed($urandom_range(0, 200000)) - 100000);
    end else if (r < 96) begin
      it.cmd = sca_pkg::CMD_CAN;
    end else begin
      it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return it;
  endfunction

  // Sender. The offered item stays on the bus until it is taken; a new offer
  // starts only after the previous one went through.
  int offer_mark = -1;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && offer_mark == items_taken) begin
        // Still waiting for the block to take it.
      end else if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_items[0].cmd;
        s_axis_tdata  <= {3'b000, pending_items[0].rdy, pending_items[0].tms,
                          pending_items[0].srcs, pending_items[0].stop,
                          pending_items[0].steer, pending_items[0].opm};
        offer_mark = items_taken;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. After a hundred results it holds off once for a long stretch,
  // so that the block fills up and has to stall its input.
  int  rx_hold = 0;
  bit  rx_held_once = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (status_taken >= 100 && !rx_held_once) begin
        rx_held_once <= 1'b1;
        rx_hold <= RX_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Input monitor: every item taken is run through the shadow model.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_status.push_back(arbitrate(pending_items[0]));
      void'(pending_items.pop_front());
      items_taken++;
    end
  end

  // Output monitor: each status word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    steer_status_t exp_st;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_taken++;
      if (expected_status.size() == 0) begin
        $error("status item with no expectation waiting: %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_st = expected_status.pop_front();
        if (m_axis_tdata[1:0] !== exp_st.mode) begin
          $error("mode: expected %0d actual %0d", exp_st.mode, m_axis_tdata[1:0]);
          error_count++;
        end
        if (m_axis_tdata[3:2] !== exp_st.src) begin
          $error("steer_source: expected %0d actual %0d", exp_st.src, m_axis_tdata[3:2]);
          error_count++;
        end
        if (m_axis_tdata[35:4] !== exp_st.tgt) begin
          $error("steer_target: expected %0d actual %0d",
                 $signed(exp_st.tgt), $signed(m_axis_tdata[35:4]));
          error_count++;
        end
        if (m_axis_tdata[36] !== exp_st.ctl) begin
          $error("control_on: expected %0d actual %0d", exp_st.ctl, m_axis_tdata[36]);
          error_count++;
        end
        if (m_axis_tdata[37] !== exp_st.srv) begin
          $error("servo_on: expected %0d actual %0d", exp_st.srv, m_axis_tdata[37]);
          error_count++;
        end
        if (m_axis_tdata[38] !== exp_st.eto) begin
          $error("eth_timed_out: expected %0d actual %0d", exp_st.eto, m_axis_tdata[38]);
          error_count++;
        end
        if (m_axis_tdata[39] !== exp_st.cto) begin
          $error("can_timed_out: expected %0d actual %0d", exp_st.cto, m_axis_tdata[39]);
          error_count++;
        end
        if (m_axis_tdata[42:40] !== exp_st.est) begin
          $error("last_estop_sources: expected %0d actual %0d",
                 exp_st.est, m_axis_tdata[42:40]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes one register and mirrors it in the shadow configuration.
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sca_pkg::REG_LINK_MODE: sh_link = value[1:0];
      sca_pkg::REG_TO_REL:    sh_release = value[1:0];
      sca_pkg::REG_ETH_TO:    sh_eth_to = value;
      sca_pkg::REG_CAN_TO:    sh_can_to = value;
      sca_pkg::REG_ADC_MIN:   sh_adc_min = value;
      sca_pkg::REG_ADC_MAX:   sh_adc_max = value;
      sca_pkg::REG_ADC_CTR:   sh_adc_ctr = value;
      sca_pkg::REG_ADC_DB:    sh_adc_db = value[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every item went in and every status came back, then lets the
  // block settle for a little longer than one long item takes.
  task automatic drain();
    while (pending_items.size() != 0 || expected_status.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_all(logic [1:0] link, logic [1:0] rel, logic [15:0] eth_to,
                           logic [15:0] can_to, logic [15:0] mn, logic [15:0] mx,
                           logic [15:0] ctr, logic [15:0] db);
    write_reg(sca_pkg::REG_LINK_MODE, {14'd0, link});
    write_reg(sca_pkg::REG_TO_REL, {14'd0, rel});
    write_reg(sca_pkg::REG_ETH_TO, eth_to);
    write_reg(sca_pkg::REG_CAN_TO, can_to);
    write_reg(sca_pkg::REG_ADC_MIN, mn);
    write_reg(sca_pkg::REG_ADC_MAX, mx);
    write_reg(sca_pkg::REG_ADC_CTR, ctr);
    write_reg(sca_pkg::REG_ADC_DB, db);
  endtask

  task automatic random_phase(int count, bit pause_midway);
    for (int i = 0; i < count; i++) begin
      pending_items.push_back(random_item());
      // The sender pauses once until every expected status has come back.
      if (pause_midway && i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset configuration (ethernet only).
    pending_items.push_back(make_item(sca_pkg::CMD_PC, 8'd0, 32'd100, 1'b0, 3'd0, 32'd5, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_AUTO, 32'd0, 1'b0, 3'd0,
                                      32'd6, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_PC, 8'd0, 32'h7FFF_FFFF, 1'b0, 3'd0,
                                      32'd10, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_PC, 8'd0, 32'h8000_0000, 1'b0, 3'd0,
                                      32'd11, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_PC, 8'd0, 32'd1234, 1'b0, 3'd0,
                                      32'd12, 1'b0));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'h0000_7FFF,
                                      1'b0, 3'd0, 32'd20, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'hFFFF_8000,
                                      1'b0, 3'd0, 32'd21, 1'b1));
    // Just inside and just outside the deadband around the centre.
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'd2068,
                                      1'b0, 3'd0, 32'd22, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'd2069,
                                      1'b0, 3'd0, 32'd23, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_TICK, 8'd0, 32'd0, 1'b0, 3'd0,
                                      32'd400, 1'b1));
    // Time that wrapped around since the last command.
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'd3000,
                                      1'b0, 3'd0, 32'hFFFF_FFF0, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_TICK, 8'd0, 32'd0, 1'b0, 3'd0, 32'd5, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_TICK, 8'd0, 32'd0, 1'b0, 3'd0,
                                      32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, 8'hFF, 32'd100, 1'b0, 3'd0,
                                      32'd30, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_ESTOP, 32'd0, 1'b0, 3'd0,
                                      32'd31, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_ESTOP, 8'd0, 32'd0, 1'b0, 3'd7,
                                      32'd32, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_ESTOP, 8'd0, 32'd0, 1'b0, sca_pkg::ESRC_CAN,
                                      32'd33, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_CAN, 8'd0, 32'd500, 1'b0, 3'd0,
                                      32'd34, 1'b1));
    pending_items.push_back(make_item(CMD_SPARE_LO, 8'd0, 32'd0, 1'b0, 3'd0, 32'd35, 1'b1));
    pending_items.push_back(make_item(CMD_SPARE_HI, 8'hFF, 32'hFFFF_FFFF, 1'b1, 3'd7,
                                      32'hFFFF_FFFF, 1'b1));
    // A packet stamped zero counts as never received for the timeout.
    pending_items.push_back(make_item(sca_pkg::CMD_OPER, sca_pkg::OPM_MANUAL, 32'd1000,
                                      1'b0, 3'd0, 32'd0, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_TICK, 8'd0, 32'd0, 1'b0, 3'd0,
                                      32'd60000, 1'b1));
    pending_items.push_back(make_item(sca_pkg::CMD_PC, 8'd0, 32'd0, 1'b1, 3'd0, 32'd40, 1'b1));
    drain();

    // Both links, every timeout releasing, symmetric operator range.
    write_all(2'd2, 2'd3, 16'd50, 16'd80, -16'sd2000, 16'd2000, 16'd0, 16'd0);
    random_phase(PHASE_ITEMS, 1'b0);
    // CAN only, widest raw range with the deadband at its top.
    write_all(sca_pkg::LINK_CAN_ONLY, 2'd2, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'd0,
              16'h7FFF);
    random_phase(PHASE_ITEMS, 1'b1);
    // The unused link code, zero operator spans.
    write_all(2'd3, 2'd1, 16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd100, 16'd5);
    random_phase(PHASE_ITEMS, 1'b0);
    // Ethernet only with an off-centre range and no idling on either side.
    write_all(sca_pkg::LINK_ETH_ONLY, 2'd0, 16'd300, 16'd300, 16'd0, 16'd4095, 16'd3000,
              16'd20);
    calm = 1'b1;
    random_phase(PHASE_ITEMS, 1'b0);
    calm = 1'b0;
    // CAN only with releasing timeouts, centre at the low end of the range.
    write_all(sca_pkg::LINK_CAN_ONLY, 2'd3, 16'd100, 16'd100, 16'h8000, 16'h7FFF, 16'h8000,
              16'd1);
    random_phase(PHASE_ITEMS, 1'b0);
    // Back to both links with a lopsided range around a negative centre.
    write_all(2'd2, 2'd1, 16'd150, 16'd40, -16'sd5000, 16'd300, -16'sd1000, 16'd50);
    random_phase(PHASE_ITEMS, 1'b0);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
